>>> rtl/core/cbls_pkg.sv
`timescale 1ns / 1ps

package cbls_pkg;

  // Coordinate and derived widths.
  localparam int COORD_W    = 12;
  localparam int ROW_OFF_W  = 10;
  localparam int PY_W       = COORD_W + 1;
  localparam int SPAN_W     = COORD_W;
  localparam int NSPAN_W    = COORD_W + 1;
  localparam int ERR_W      = COORD_W + 2;
  localparam int E2_W       = ERR_W + 1;
  localparam int CFG_DATA_W = (COORD_W > ROW_OFF_W) ? COORD_W : ROW_OFF_W;
  localparam int CFG_ADDR_W = 3;

  // Command queue between the front and the back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  // Reset values of the window and the row offset.
  localparam coord_t                CLIP_MIN_RESET = '0;
  localparam coord_t                CLIP_MAX_RESET = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [ROW_OFF_W-1:0]  ROW_OFF_RESET  = ROW_OFF_W'(100);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CLIP_X_MIN  = 3'd0,
    REG_CLIP_X_MAX  = 3'd1,
    REG_CLIP_Y_MIN  = 3'd2,
    REG_CLIP_Y_MAX  = 3'd3,
    REG_ROW_OFFSET  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_DROP = 2'd2
  } cmd_op_e;

  typedef struct packed {
    coord_t                x_min;
    coord_t                x_max;
    coord_t                y_min;
    coord_t                y_max;
    logic [ROW_OFF_W-1:0]  row_offset;
  } cfg_t;

  // A load command carries the segment already ordered: trace from a to b.
  typedef struct packed {
    cmd_op_e op;
    coord_t  ax;
    coord_t  ay;
    coord_t  bx;
    coord_t  by;
  } cmd_t;

  // Inclusive clip window test.
  function automatic logic in_window(coord_t x, coord_t y, cfg_t cfg);
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
    x_min = cfg.x_min;
    x_max = cfg.x_max;
    y_min = cfg.y_min;
    y_max = cfg.y_max;
    return (x >= x_min) && (x <= x_max) && (y >= y_min) && (y <= y_max);
  endfunction

endpackage

>>> rtl/core/cbls_cfg_regs.sv
`timescale 1ns / 1ps

module cbls_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cbls_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [cbls_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output cbls_pkg::cfg_t                     cfg_o
);
  import cbls_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the register index; writes to unused indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CLIP_X_MIN: cfg_d.x_min      = coord_t'(cfg_wdata_i[COORD_W-1:0]);
        REG_CLIP_X_MAX: cfg_d.x_max      = coord_t'(cfg_wdata_i[COORD_W-1:0]);
        REG_CLIP_Y_MIN: cfg_d.y_min      = coord_t'(cfg_wdata_i[COORD_W-1:0]);
        REG_CLIP_Y_MAX: cfg_d.y_max      = coord_t'(cfg_wdata_i[COORD_W-1:0]);
        REG_ROW_OFFSET: cfg_d.row_offset = cfg_wdata_i[ROW_OFF_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min      <= CLIP_MIN_RESET;
      cfg_q.x_max      <= CLIP_MAX_RESET;
      cfg_q.y_min      <= CLIP_MIN_RESET;
      cfg_q.y_max      <= CLIP_MAX_RESET;
      cfg_q.row_offset <= ROW_OFF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/cbls_front.sv
`timescale 1ns / 1ps

module cbls_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_kind_i,
  input  cbls_pkg::coord_t  in_start_x_i,
  input  cbls_pkg::coord_t  in_start_y_i,
  input  cbls_pkg::coord_t  in_end_x_i,
  input  cbls_pkg::coord_t  in_end_y_i,
  input  cbls_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cbls_pkg::cmd_t    q_cmd_o
);
  import cbls_pkg::*;

  logic start_in;
  logic end_in;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Pick the starting endpoint with the window in force at the load.
  assign start_in = in_window(in_start_x_i, in_start_y_i, cfg_i);
  assign end_in   = in_window(in_end_x_i, in_end_y_i, cfg_i);

  always_comb begin
    q_cmd_o.ax = in_start_x_i;
    q_cmd_o.ay = in_start_y_i;
    q_cmd_o.bx = in_end_x_i;
    q_cmd_o.by = in_end_y_i;
    if (item_kind_e'(in_kind_i) == KIND_STEP) begin
      q_cmd_o.op = CMD_STEP;
    end else if (start_in) begin
      q_cmd_o.op = CMD_LOAD;
    end else if (end_in) begin
      // Trace backwards from the second endpoint.
      q_cmd_o.op = CMD_LOAD;
      q_cmd_o.ax = in_end_x_i;
      q_cmd_o.ay = in_end_y_i;
      q_cmd_o.bx = in_start_x_i;
      q_cmd_o.by = in_start_y_i;
    end else begin
      q_cmd_o.op = CMD_DROP;
    end
  end

endmodule

>>> rtl/core/cbls_cmd_fifo.sv
`timescale 1ns / 1ps

module cbls_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbls_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cbls_pkg::cmd_t  head_o
);
  import cbls_pkg::*;

  localparam logic [CMDQ_PTR_W-1:0] LAST_PTR = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CMDQ_CNT_W-1:0] FULL_CNT = CMDQ_CNT_W'(CMDQ_DEPTH);

  cmd_t                  entries_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q;
  logic [CMDQ_PTR_W-1:0] wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q;
  logic [CMDQ_PTR_W-1:0] rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] count_q;
  logic [CMDQ_CNT_W-1:0] count_d;
  logic                  do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/cbls_back.sv
`timescale 1ns / 1ps

module cbls_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cbls_pkg::cfg_t               cfg_i,
  input  logic                         cmd_valid_i,
  input  cbls_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cbls_pkg::coord_t             out_pixel_x_o,
  output logic [cbls_pkg::PY_W-1:0]    out_pixel_y_o,
  output logic                         out_draw_o,
  output logic                         out_last_o
);
  import cbls_pkg::*;

  // Line state.
  logic                       active_q, active_d;
  coord_t                     cur_x_q, cur_x_d;
  coord_t                     cur_y_q, cur_y_d;
  coord_t                     tgt_x_q, tgt_x_d;
  coord_t                     tgt_y_q, tgt_y_d;
  logic        [SPAN_W-1:0]   span_x_q, span_x_d;
  logic signed [NSPAN_W-1:0]  nspan_y_q, nspan_y_d;
  logic                       right_q, right_d;
  logic                       down_q, down_d;
  logic signed [ERR_W-1:0]    err_q, err_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  coord_t                     px_q, px_d;
  logic        [PY_W-1:0]     py_q, py_d;
  logic                       draw_q, draw_d;
  logic                       last_q, last_d;

  // Load arithmetic.
  logic signed [COORD_W:0]    dx;
  logic signed [COORD_W:0]    dy;
  logic signed [COORD_W:0]    dx_mag;
  logic        [SPAN_W-1:0]   span_new;
  logic signed [NSPAN_W-1:0]  nspan_new;

  // Step arithmetic.
  logic signed [E2_W-1:0]     e2;
  logic signed [E2_W-1:0]     nspan_e2;
  logic signed [E2_W-1:0]     span_e2;
  logic signed [ERR_W-1:0]    err_add_x;
  logic signed [ERR_W-1:0]    err_add_y;
  logic                       move_x;
  logic                       move_y;
  logic                       fin;
  logic                       out_free;
  logic                       emit;

  assign out_free = !out_valid_q || out_ready_i;
  // A step on a live line waits for the output register; anything else goes at once.
  assign cmd_pop_o = cmd_valid_i && ((cmd_i.op != CMD_STEP) || !active_q || out_free);
  assign emit      = cmd_valid_i && (cmd_i.op == CMD_STEP) && active_q && out_free;

  // Segment setup values.
  assign dx        = {cmd_i.bx[COORD_W-1], cmd_i.bx} - {cmd_i.ax[COORD_W-1], cmd_i.ax};
  assign dy        = {cmd_i.by[COORD_W-1], cmd_i.by} - {cmd_i.ay[COORD_W-1], cmd_i.ay};
  assign dx_mag    = dx[COORD_W] ? -dx : dx;
  assign span_new  = dx_mag[SPAN_W-1:0];
  assign nspan_new = dy[COORD_W] ? dy : -dy;

  // Bresenham decision on the doubled error term.
  assign e2       = {err_q, 1'b0};
  assign nspan_e2 = {{(E2_W-NSPAN_W){nspan_y_q[NSPAN_W-1]}}, nspan_y_q};
  assign span_e2  = {{(E2_W-SPAN_W){1'b0}}, span_x_q};
  assign move_x   = (e2 >= nspan_e2);
  assign move_y   = (e2 <= span_e2);
  assign err_add_x = move_x ? {{(ERR_W-NSPAN_W){nspan_y_q[NSPAN_W-1]}}, nspan_y_q} : '0;
  assign err_add_y = move_y ? {{(ERR_W-SPAN_W){1'b0}}, span_x_q} : '0;
  assign fin      = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  always_comb begin
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    span_x_d    = span_x_q;
    nspan_y_d   = nspan_y_q;
    right_d     = right_q;
    down_d      = down_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    px_d        = px_q;
    py_d        = py_q;
    draw_d      = draw_q;
    last_d      = last_q;

    if (cmd_pop_o) begin
      case (cmd_i.op)
        CMD_LOAD: begin
          active_d  = 1'b1;
          cur_x_d   = cmd_i.ax;
          cur_y_d   = cmd_i.ay;
          tgt_x_d   = cmd_i.bx;
          tgt_y_d   = cmd_i.by;
          span_x_d  = span_new;
          nspan_y_d = nspan_new;
          right_d   = (cmd_i.ax < cmd_i.bx);
          down_d    = (cmd_i.ay < cmd_i.by);
          err_d     = {{(ERR_W-SPAN_W){1'b0}}, span_new}
                    + {{(ERR_W-NSPAN_W){nspan_new[NSPAN_W-1]}}, nspan_new};
        end
        CMD_DROP: begin
          active_d = 1'b0;
        end
        CMD_STEP: begin
          if (emit) begin
            out_valid_d = 1'b1;
            px_d        = cur_x_q;
            py_d        = {cur_y_q[COORD_W-1], cur_y_q}
                        + {{(PY_W-ROW_OFF_W){1'b0}}, cfg_i.row_offset};
            draw_d      = in_window(cur_x_q, cur_y_q, cfg_i);
            last_d      = fin;
            if (fin) begin
              active_d = 1'b0;
            end else begin
              err_d = err_q + err_add_x + err_add_y;
              if (move_x) begin
                cur_x_d = right_q ? cur_x_q + 1'b1 : cur_x_q - 1'b1;
              end
              if (move_y) begin
                cur_y_d = down_q ? cur_y_q + 1'b1 : cur_y_q - 1'b1;
              end
            end
          end
        end
        default: active_d = active_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      span_x_q    <= '0;
      nspan_y_q   <= '0;
      right_q     <= 1'b0;
      down_q      <= 1'b0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      span_x_q    <= span_x_d;
      nspan_y_q   <= nspan_y_d;
      right_q     <= right_d;
      down_q      <= down_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    draw_q <= draw_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_pixel_x_o = px_q;
  assign out_pixel_y_o = py_q;
  assign out_draw_o    = draw_q;
  assign out_last_o    = last_q;

endmodule

>>> rtl/core/clipped_bresenham_line_stepper_top.sv
`timescale 1ns / 1ps

// Clipped Bresenham line stepper. A load item (kind 0) hands over a segment; it is
// traced from the first endpoint if that lies inside the inclusive clip window, else
// from the second endpoint if that one is inside, else it is dropped and no line is
// active. Each step item (kind 1) on an active line yields one point with its draw
// flag, y plus the row offset, and a last flag on the end point; a step with no
// active line yields nothing, and loads yield nothing. The block takes one item per
// cycle while the queue is not full: the front classifies loads against the window
// and writes a two-entry command queue, and the back executes one command per cycle
// (one Bresenham step, a few narrow adds and compares) into an output register, a
// step on a live line only once that register is free. A step item goes through the
// queue, and its result is registered in the output register. While the receiver
// stalls, steps back up in the queue; input is held off once it is full. The user
// writes configuration only while the block is idle; the block does not enforce it.
module clipped_bresenham_line_stepper_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cbls_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [cbls_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_kind_i,
  input  cbls_pkg::coord_t                  in_start_x_i,
  input  cbls_pkg::coord_t                  in_start_y_i,
  input  cbls_pkg::coord_t                  in_end_x_i,
  input  cbls_pkg::coord_t                  in_end_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cbls_pkg::coord_t                  out_pixel_x_o,
  output logic [cbls_pkg::PY_W-1:0]         out_pixel_y_o,
  output logic                              out_draw_o,
  output logic                              out_last_o
);
  import cbls_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  // Clip window and row offset.
  cbls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Item intake and classification.
  cbls_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_kind_i    (in_kind_i),
    .in_start_x_i (in_start_x_i),
    .in_start_y_i (in_start_y_i),
    .in_end_x_i   (in_end_x_i),
    .in_end_y_i   (in_end_y_i),
    .cfg_i        (cfg),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd)
  );

  // Command queue.
  cbls_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Line tracing and result register.
  cbls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_head),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_pixel_x_o (out_pixel_x_o),
    .out_pixel_y_o (out_pixel_y_o),
    .out_draw_o    (out_draw_o),
    .out_last_o    (out_last_o)
  );

endmodule

>>> rtl/core/cbls_checker.sv
`timescale 1ns / 1ps

module cbls_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  cbls_pkg::coord_t              out_pixel_x_o,
  input  logic [cbls_pkg::PY_W-1:0]     out_pixel_y_o,
  input  logic                          out_draw_o,
  input  logic                          out_last_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_pixel_x_o) && $stable(out_pixel_y_o)
                                    && $stable(out_draw_o) && $stable(out_last_o))
    else $error("result payload changed while stalled");

  // With the result register empty the back drains the queue, so intake is open.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("intake blocked with no pending result");

  // No result is offered and intake is open right out of reset.
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("result or stall right after reset");

endmodule

bind clipped_bresenham_line_stepper_top cbls_checker u_cbls_checker (.*);

>>> sim/tb_clipped_bresenham_line_stepper_top.sv
`timescale 1ns / 1ps

module tb_clipped_bresenham_line_stepper_top;
  import cbls_pkg::*;

  localparam int ITEM_TARGET   = 1100;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_STEPS     = 64;
  localparam int DIR_ROWS      = 25;
  localparam int COORD_LO      = -(1 << (COORD_W - 1));
  localparam int COORD_HI      = (1 << (COORD_W - 1)) - 1;
  localparam coord_t CMIN      = coord_t'(COORD_LO);
  localparam coord_t CMAX      = coord_t'(COORD_HI);

  // One emitted line point.
  typedef struct packed {
    coord_t          x;
    logic [PY_W-1:0] y;
    logic            draw;
    logic            last;
  } pixel_t;

  // One row of the directed table; typed rows carry the point by hand.
  typedef struct packed {
    item_kind_e kind;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    logic       typed;
    pixel_t     pix;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_kind;
  coord_t                in_sx;
  coord_t                in_sy;
  coord_t                in_ex;
  coord_t                in_ey;
  logic                  out_valid;
  logic                  out_ready;
  coord_t                out_x;
  logic [PY_W-1:0]       out_y;
  logic                  out_draw;
  logic                  out_last;

  // Window and row offset as the block should hold them.
  int win_x_lo;
  int win_x_hi;
  int win_y_lo;
  int win_y_hi;
  int row_shift;

  // Line tracer state.
  logic line_on;
  int   pos_x;
  int   pos_y;
  int   goal_x;
  int   goal_y;
  int   run_x;
  int   neg_run_y;
  logic dir_x_pos;
  logic dir_y_pos;
  int   err_term;

  pixel_t    pix_pend[$];
  stim_row_t stim_tab[DIR_ROWS];
  int        mismatches;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  clipped_bresenham_line_stepper_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_kind_i     (in_kind),
    .in_start_x_i  (in_sx),
    .in_start_y_i  (in_sy),
    .in_end_x_i    (in_ex),
    .in_end_y_i    (in_ey),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_pixel_x_o (out_x),
    .out_pixel_y_o (out_y),
    .out_draw_o    (out_draw),
    .out_last_o    (out_last)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic in_clip(int x, int y);
    return (x >= win_x_lo) && (x <= win_x_hi) && (y >= win_y_lo) && (y <= win_y_hi);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < COORD_LO) ? COORD_LO : ((v > COORD_HI) ? COORD_HI : v);
  endfunction

  // Sets up a trace from (ax, ay) toward (bx, by).
  function automatic void begin_trace(int ax, int ay, int bx, int by);
    pos_x     = ax;
    pos_y     = ay;
    goal_x    = bx;
    goal_y    = by;
    run_x     = (bx > ax) ? bx - ax : ax - bx;
    neg_run_y = (by > ay) ? ay - by : by - ay;
    dir_x_pos = ax < bx;
    dir_y_pos = ay < by;
    err_term  = run_x + neg_run_y;
    line_on   = 1'b1;
  endfunction

  // Applies one item to the tracer; returns 1 when it emits a point.
  function automatic logic trace_item(input item_kind_e kind, input coord_t sx, sy, ex, ey,
                                      output pixel_t pix);
    int e2;
    pix = '0;
    if (kind == KIND_LOAD) begin
      if (in_clip(sx, sy)) begin
        begin_trace(sx, sy, ex, ey);
      end else if (in_clip(ex, ey)) begin
        begin_trace(ex, ey, sx, sy);
      end else begin
        line_on = 1'b0;
      end
      return 1'b0;
    end
    if (!line_on) begin
      return 1'b0;
    end
    pix.x    = coord_t'(pos_x);
    pix.y    = PY_W'(pos_y + row_shift);
    pix.draw = in_clip(pos_x, pos_y);
    pix.last = (pos_x == goal_x) && (pos_y == goal_y);
    if (pix.last) begin
      line_on = 1'b0;
    end else begin
      e2 = 2 * err_term;
      if (e2 >= neg_run_y) begin
        err_term += neg_run_y;
        pos_x    += dir_x_pos ? 1 : -1;
      end
      if (e2 <= run_x) begin
        err_term += run_x;
        pos_y    += dir_y_pos ? 1 : -1;
      end
    end
    return 1'b1;
  endfunction

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (cfg_reg_e'(idx))
      REG_CLIP_X_MIN: win_x_lo = $signed(data[COORD_W-1:0]);
      REG_CLIP_X_MAX: win_x_hi = $signed(data[COORD_W-1:0]);
      REG_CLIP_Y_MIN: win_y_lo = $signed(data[COORD_W-1:0]);
      REG_CLIP_Y_MAX: win_y_hi = $signed(data[COORD_W-1:0]);
      REG_ROW_OFFSET: row_shift = data[ROW_OFF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes the whole window plus one index that maps to no register.
  task automatic program_window(input int xlo, input int xhi, input int ylo, input int yhi,
                                input int row);
    int spare;
    spare = int'(REG_ROW_OFFSET) + 1 +
            $urandom_range((1 << CFG_ADDR_W) - 2 - int'(REG_ROW_OFFSET));
    write_reg(REG_CLIP_X_MIN, xlo);
    write_reg(REG_CLIP_X_MAX, xhi);
    write_reg(REG_CLIP_Y_MIN, ylo);
    write_reg(REG_CLIP_Y_MAX, yhi);
    write_reg(REG_ROW_OFFSET, row);
    write_reg(CFG_ADDR_W'(spare), $urandom);
  endtask

  // Presents one item, waits for acceptance and records the expected point.
  task automatic send_item(input item_kind_e kind, input coord_t sx, sy, ex, ey,
                           input logic use_typed, input pixel_t typed_pix,
                           output logic emitted);
    pixel_t pix;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_sx    <= sx;
    in_sy    <= sy;
    in_ex    <= ex;
    in_ey    <= ey;
    do @(posedge clk); while (in_ready !== 1'b1);
    emitted = trace_item(kind, sx, sy, ex, ey, pix);
    if (emitted) begin
      pix_pend.push_back(use_typed ? typed_pix : pix);
    end
  endtask

  // Holds the sender off until every expected point has come out.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pix_pend.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted point with the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_x, out_y, out_draw, out_last};
      if (pix_pend.size() == 0) begin
        mismatches++;
        if (mismatches < 30) begin
          $display("%0t: unexpected point x=%0d y=%0d draw=%0b last=%0b", $time,
                   $signed(got.x), $signed(got.y), got.draw, got.last);
        end
      end else begin
        want = pix_pend.pop_front();
        if (want.x !== got.x || want.y !== got.y || want.draw !== got.draw ||
            want.last !== got.last) begin
          mismatches++;
          if (mismatches < 30) begin
            $display("%0t: point mismatch: expected x=%0d y=%0d draw=%0b last=%0b, got x=%0d y=%0d draw=%0b last=%0b",
                     $time, $signed(want.x), $signed(want.y), want.draw, want.last,
                     $signed(got.x), $signed(got.y), got.draw, got.last);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_clipped_bresenham_line_stepper_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int     ph;
    int     sent;
    int     steps;
    int     ax;
    int     ay;
    int     bx;
    int     by;
    int     tmp;
    int     xl;
    int     yl;
    logic   emitted;
    logic   open_win;

    // Everything driven from time zero; tracer starts in its reset state.
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_kind        = KIND_LOAD;
    in_sx          = '0;
    in_sy          = '0;
    in_ex          = '0;
    in_ey          = '0;
    out_ready      = 1'b0;
    rst_n          = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    win_x_lo       = int'(CLIP_MIN_RESET);
    win_x_hi       = int'(CLIP_MAX_RESET);
    win_y_lo       = int'(CLIP_MIN_RESET);
    win_y_hi       = int'(CLIP_MAX_RESET);
    row_shift      = int'(ROW_OFF_RESET);
    line_on        = 1'b0;
    pos_x          = 0;
    pos_y          = 0;
    goal_x         = 0;
    goal_y         = 0;
    run_x          = 0;
    neg_run_y      = 0;
    dir_x_pos      = 1'b0;
    dir_y_pos      = 1'b0;
    err_term       = 0;

    // Directed items under the reset window (0..2047 both ways, row offset 100).
    stim_tab = '{
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, 12'sd0, 12'sd0, 12'sd2, 12'sd1, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, '{12'sd0, 13'sd100, 1'b1, 1'b0}},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, '{12'sd2, 13'sd101, 1'b1, 1'b1}},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, -12'sd5, 12'sd3, 12'sd4, 12'sd3, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, '{12'sd4, 13'sd103, 1'b1, 1'b0}},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, -12'sd1, -12'sd1, -12'sd3, 12'sd5, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, CMAX, CMAX, CMIN, CMIN, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, '{CMAX, 13'sd2147, 1'b1, 1'b0}},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, '{12'sd0, 13'sd100, 1'b1, 1'b1}},
      '{KIND_LOAD, CMIN, CMIN, 12'sd10, 12'sd10, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, '{12'sd10, 13'sd110, 1'b1, 1'b0}},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, CMIN, CMAX, CMAX, CMIN, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_LOAD, 12'sd3, 12'sd3, 12'sd4, 12'sd9, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0},
      '{KIND_STEP, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[i]) begin
      send_item(stim_tab[i].kind, stim_tab[i].sx, stim_tab[i].sy, stim_tab[i].ex,
                stim_tab[i].ey, stim_tab[i].typed, stim_tab[i].pix, emitted);
    end

    // Shrink the window under the steep line that is still being traced.
    wait_results_done();
    write_reg(REG_CLIP_Y_MAX, 4);
    repeat (3) send_item(KIND_STEP, '0, '0, '0, '0, 1'b0, '0, emitted);

    // An empty window drops every segment.
    wait_results_done();
    write_reg(REG_CLIP_X_MIN, 12);
    write_reg(REG_CLIP_X_MAX, 11);
    send_item(KIND_LOAD, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 1'b0, '0, emitted);
    send_item(KIND_STEP, '0, '0, '0, '0, 1'b0, '0, emitted);

    // Random phases, each with its own window and idling pattern.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      case (ph % 4)
        1: send_idle_pct = 81;
        2: recv_stall_pct = 81;
        3: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
        default: ;
      endcase

      xl = COORD_LO + $urandom_range(COORD_HI - COORD_LO);
      yl = COORD_LO + $urandom_range(COORD_HI - COORD_LO);
      case (ph)
        0: program_window(COORD_LO, COORD_HI, COORD_LO, COORD_HI, 0);
        1: program_window(COORD_LO, COORD_HI, COORD_LO, COORD_HI, (1 << CFG_DATA_W) - 1);
        3: begin
          xl = $urandom_range(4000) - 2000;
          program_window(xl, xl - 1 - $urandom_range(5), yl, clamp_coord(yl + 200),
                         $urandom);
        end
        6: program_window($urandom, $urandom, $urandom, $urandom, $urandom);
        default: program_window(xl, clamp_coord(xl + $urandom_range(400)), yl,
                                clamp_coord(yl + $urandom_range(400)), $urandom);
      endcase

      sent = 0;
      while (sent < ITEM_TARGET / PHASES) begin
        if ($urandom_range(99) < 8) begin
          // Noise: any kind, any endpoints.
          send_item(item_kind_e'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), 1'b0, '0, emitted);
          sent++;
        end else begin
          // A segment near the window, usually with one endpoint inside it.
          open_win = (win_x_lo <= win_x_hi) && (win_y_lo <= win_y_hi);
          if (open_win && $urandom_range(99) < 85) begin
            ax = win_x_lo + $urandom_range(win_x_hi - win_x_lo);
            ay = win_y_lo + $urandom_range(win_y_hi - win_y_lo);
          end else begin
            ax = int'(coord_t'($urandom));
            ay = int'(coord_t'($urandom));
          end
          if ($urandom_range(99) < 15) begin
            bx = int'(coord_t'($urandom));
            by = int'(coord_t'($urandom));
          end else begin
            bx = clamp_coord(ax + int'($urandom_range(40)) - 20);
            by = clamp_coord(ay + int'($urandom_range(40)) - 20);
          end
          if ($urandom_range(1) == 1) begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
          end
          send_item(KIND_LOAD, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                    1'b0, '0, emitted);
          sent++;

          // Usually run the line to its end, sometimes cut it short or overrun it.
          if (line_on) begin
            steps = ((run_x > -neg_run_y) ? run_x : -neg_run_y) + 1;
          end else begin
            steps = $urandom_range(2);
          end
          if ($urandom_range(99) < 20) begin
            steps = $urandom_range(steps);
          end else begin
            steps += $urandom_range(2);
          end
          if (steps > MAX_STEPS) begin
            steps = MAX_STEPS;
          end
          repeat (steps) begin
            send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), 1'b0, '0, emitted);
            if (emitted) begin
              sent++;
            end
          end
        end
        if ($urandom_range(99) < 2) begin
          wait_results_done();
        end
      end
    end

    wait_results_done();
    if (mismatches == 0) begin
      $display("tb_clipped_bresenham_line_stepper_top OK");
    end else begin
      $display("tb_clipped_bresenham_line_stepper_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cbls_pkg.sv
rtl/core/cbls_cfg_regs.sv
rtl/core/cbls_front.sv
rtl/core/cbls_cmd_fifo.sv
rtl/core/cbls_back.sv
rtl/core/clipped_bresenham_line_stepper_top.sv
rtl/core/cbls_checker.sv
sim/tb_clipped_bresenham_line_stepper_top.sv
